// ===== src/vvps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vvps_pkg;

    // Fixed point format of positions, velocities and forces
    localparam int FRAC_BITS = 16;

    // Field widths
    localparam int POS_W = 31;
    localparam int VEL_W = 32;
    localparam int DT_W  = 17;
    localparam int LEN_W = 31;
    localparam int CNT_W = 16;

    // Configuration port
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIN_MARGIN = 2'd2;

    localparam logic [DT_W-1:0]  RST_TIME_STEP   = 17'd328;
    localparam logic [LEN_W-1:0] RST_BOX_LENGTH  = 31'd655360;
    localparam logic [LEN_W-1:0] RST_SKIN_MARGIN = 31'd19661;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Item class decided at the front
    typedef enum logic [1:0] {
        KIND_KICK,
        KIND_DRIFT,
        KIND_DRIFT_LAST
    } t_kind;

    typedef struct packed {
        t_kind                   kind;
        logic [2:0][POS_W-1:0]   pos;
        logic [2:0][VEL_W-1:0]   vel;
        logic [2:0][VEL_W-1:0]   force_in;
    } t_item;

    typedef struct packed {
        logic [DT_W-1:0]  time_step;
        logic [LEN_W-1:0] box_length;
        logic [LEN_W-1:0] skin_margin;
    } t_cfg;

endpackage

`default_nettype wire

// ===== src/velocity_verlet_particle_step_top.sv =====
// Velocity Verlet step for one particle per item in a periodic cubic box, Q16.16 fixed
// point. An item is queued by the front end (two entries) and worked off by a back end
// that shares a single 33x33 multiplier, one product per cycle while the output register
// can take a result, so an item's time grows with its multiplies: a kick-only item runs
// only the kick products, a drift item adds the drift products and squares, and the last
// drift item of a pass adds the rebuild test products. The input side keeps taking items
// while the queue has room, and the output register holds a finished result while the next
// item is being worked. Configuration (time step, box length, skin margin) is written
// through a plain write port and must only change while the block is empty.
`timescale 1ns / 1ps
`default_nettype none

module velocity_verlet_particle_step_top (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire [vvps_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [vvps_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire                             i_action,
    input  wire [vvps_pkg::POS_W-1:0]       i_pos_x,
    input  wire [vvps_pkg::POS_W-1:0]       i_pos_y,
    input  wire [vvps_pkg::POS_W-1:0]       i_pos_z,
    input  wire [vvps_pkg::VEL_W-1:0]       i_vel_x,
    input  wire [vvps_pkg::VEL_W-1:0]       i_vel_y,
    input  wire [vvps_pkg::VEL_W-1:0]       i_vel_z,
    input  wire [vvps_pkg::VEL_W-1:0]       i_force_x,
    input  wire [vvps_pkg::VEL_W-1:0]       i_force_y,
    input  wire [vvps_pkg::VEL_W-1:0]       i_force_z,
    input  wire                             i_last_particle,
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output logic [vvps_pkg::POS_W-1:0]      o_new_pos_x,
    output logic [vvps_pkg::POS_W-1:0]      o_new_pos_y,
    output logic [vvps_pkg::POS_W-1:0]      o_new_pos_z,
    output logic [vvps_pkg::VEL_W-1:0]      o_new_vel_x,
    output logic [vvps_pkg::VEL_W-1:0]      o_new_vel_y,
    output logic [vvps_pkg::VEL_W-1:0]      o_new_vel_z,
    output logic [vvps_pkg::VEL_W-1:0]      o_disp_x,
    output logic [vvps_pkg::VEL_W-1:0]      o_disp_y,
    output logic [vvps_pkg::VEL_W-1:0]      o_disp_z,
    output logic                            o_rebuild_list
);

    vvps_pkg::t_cfg                         r_cfg;
    logic                                   w_q_valid;
    vvps_pkg::t_item                        w_q_item;
    logic                                   w_pop;
    logic [2:0][vvps_pkg::POS_W-1:0]        w_new_pos;
    logic [2:0][vvps_pkg::VEL_W-1:0]        w_new_vel;
    logic [2:0][vvps_pkg::VEL_W-1:0]        w_disp;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_step   <= vvps_pkg::RST_TIME_STEP;
            r_cfg.box_length  <= vvps_pkg::RST_BOX_LENGTH;
            r_cfg.skin_margin <= vvps_pkg::RST_SKIN_MARGIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vvps_pkg::CFG_TIME_STEP: begin
                    r_cfg.time_step <= i_cfg_wdata[vvps_pkg::DT_W-1:0];
                end
                vvps_pkg::CFG_BOX_LENGTH: begin
                    r_cfg.box_length <= i_cfg_wdata[vvps_pkg::LEN_W-1:0];
                end
                vvps_pkg::CFG_SKIN_MARGIN: begin
                    r_cfg.skin_margin <= i_cfg_wdata[vvps_pkg::LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    vvps_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_pos_z         (i_pos_z),
        .i_vel_x         (i_vel_x),
        .i_vel_y         (i_vel_y),
        .i_vel_z         (i_vel_z),
        .i_force_x       (i_force_x),
        .i_force_y       (i_force_y),
        .i_force_z       (i_force_z),
        .i_last_particle (i_last_particle),
        .o_q_valid       (w_q_valid),
        .o_q_item        (w_q_item),
        .i_pop           (w_pop)
    );

    vvps_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (w_q_valid),
        .i_q_item       (w_q_item),
        .o_pop          (w_pop),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_new_pos      (w_new_pos),
        .o_new_vel      (w_new_vel),
        .o_disp         (w_disp),
        .o_rebuild_list (o_rebuild_list)
    );

    assign o_new_pos_x = w_new_pos[0];
    assign o_new_pos_y = w_new_pos[1];
    assign o_new_pos_z = w_new_pos[2];
    assign o_new_vel_x = w_new_vel[0];
    assign o_new_vel_y = w_new_vel[1];
    assign o_new_vel_z = w_new_vel[2];
    assign o_disp_x    = w_disp[0];
    assign o_disp_y    = w_disp[1];
    assign o_disp_z    = w_disp[2];

endmodule

`default_nettype wire

// ===== src/vvps_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vvps_front (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire                         i_action,
    input  wire [vvps_pkg::POS_W-1:0]   i_pos_x,
    input  wire [vvps_pkg::POS_W-1:0]   i_pos_y,
    input  wire [vvps_pkg::POS_W-1:0]   i_pos_z,
    input  wire [vvps_pkg::VEL_W-1:0]   i_vel_x,
    input  wire [vvps_pkg::VEL_W-1:0]   i_vel_y,
    input  wire [vvps_pkg::VEL_W-1:0]   i_vel_z,
    input  wire [vvps_pkg::VEL_W-1:0]   i_force_x,
    input  wire [vvps_pkg::VEL_W-1:0]   i_force_y,
    input  wire [vvps_pkg::VEL_W-1:0]   i_force_z,
    input  wire                         i_last_particle,
    output logic                        o_q_valid,
    output vvps_pkg::t_item             o_q_item,
    input  wire                         i_pop
);

    vvps_pkg::t_item                    r_mem [vvps_pkg::QUEUE_DEPTH];
    logic [vvps_pkg::QPTR_W-1:0]        r_wr_ptr, n_wr_ptr;
    logic [vvps_pkg::QPTR_W-1:0]        r_rd_ptr, n_rd_ptr;
    logic [vvps_pkg::QCNT_W-1:0]        r_count, n_count;
    vvps_pkg::t_item                    w_item;
    logic                               w_push;
    logic                               w_pop;

    // Classify the incoming item; last_particle only matters for a drift
    always_comb begin
        if (i_action) begin
            w_item.kind = vvps_pkg::KIND_KICK;
        end else if (i_last_particle) begin
            w_item.kind = vvps_pkg::KIND_DRIFT_LAST;
        end else begin
            w_item.kind = vvps_pkg::KIND_DRIFT;
        end
        w_item.pos      = {i_pos_z, i_pos_y, i_pos_x};
        w_item.vel      = {i_vel_z, i_vel_y, i_vel_x};
        w_item.force_in = {i_force_z, i_force_y, i_force_x};
    end

    assign o_in_stall = (r_count == vvps_pkg::QCNT_W'(vvps_pkg::QUEUE_DEPTH));
    assign o_q_valid  = (r_count != '0);
    assign o_q_item   = r_mem[r_rd_ptr];
    assign w_push     = i_in_valid && !o_in_stall;
    assign w_pop      = i_pop && o_q_valid;

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == vvps_pkg::QPTR_W'(vvps_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == vvps_pkg::QPTR_W'(vvps_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    // Fill count follows pushes and pops
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
        (32'(r_count) == 32'($past(r_count)) + 32'($past(w_push)) - 32'($past(w_pop))))
        else $error("queue fill count out of step");

endmodule

`default_nettype wire

// ===== src/vvps_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vvps_back (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  vvps_pkg::t_cfg                      i_cfg,
    input  wire                                 i_q_valid,
    input  vvps_pkg::t_item                     i_q_item,
    output logic                                o_pop,
    input  wire                                 i_out_stall,
    output logic                                o_out_valid,
    output logic [2:0][vvps_pkg::POS_W-1:0]     o_new_pos,
    output logic [2:0][vvps_pkg::VEL_W-1:0]     o_new_vel,
    output logic [2:0][vvps_pkg::VEL_W-1:0]     o_disp,
    output logic                                o_rebuild_list
);

    localparam int OP_W   = vvps_pkg::VEL_W + 1;
    localparam int PROD_W = 2 * OP_W;
    localparam int P_W    = vvps_pkg::POS_W + 3;
    localparam int SQ_W   = 2 * vvps_pkg::VEL_W;
    localparam int C2_W   = 2 * vvps_pkg::CNT_W;
    localparam int S2Q_W  = 2 * vvps_pkg::LEN_W - 2;
    localparam int BIG_W  = SQ_W + C2_W;
    localparam int HALF_W = SQ_W / 2;

    localparam logic signed [PROD_W-1:0] S32_MAX = PROD_W'(32'h7FFF_FFFF);
    localparam logic signed [PROD_W-1:0] S32_MIN = ~S32_MAX;
    localparam logic [vvps_pkg::CNT_W-1:0] CNT_TOP = '1;

    typedef enum logic [4:0] {
        S_IDLE, S_KX, S_KY, S_KZ, S_KEND,
        S_DX, S_DY, S_DZ, S_DEND,
        S_SX, S_SY, S_SZ, S_SEND, S_MAX,
        S_C2, S_S2, S_PL, S_PH, S_PSUM, S_CMP,
        S_DONE
    } t_state;

    t_state                                 r_state, n_state;
    vvps_pkg::t_item                        r_item, n_item;
    logic [2:0][vvps_pkg::VEL_W-1:0]        r_vel, n_vel;
    logic [2:0][vvps_pkg::VEL_W-1:0]        r_disp, n_disp;
    logic [2:0][vvps_pkg::POS_W-1:0]        r_npos, n_npos;
    logic                                   r_rebuild, n_rebuild;
    logic signed [PROD_W-1:0]               r_prod, n_prod;
    logic signed [P_W-1:0]                  r_p, n_p;
    logic [SQ_W-1:0]                        r_acc, n_acc;
    logic [SQ_W-1:0]                        r_max, n_max;
    logic                                   r_pass_open, n_pass_open;
    logic [vvps_pkg::CNT_W-1:0]             r_cnt, n_cnt;
    logic [C2_W-1:0]                        r_c2, n_c2;
    logic [S2Q_W-1:0]                       r_s2q, n_s2q;
    logic [SQ_W-1:0]                        r_pl, n_pl;
    logic [BIG_W-1:0]                       r_pbig, n_pbig;
    logic                                   r_out_valid, n_out_valid;
    logic [2:0][vvps_pkg::POS_W-1:0]        r_out_pos, n_out_pos;
    logic [2:0][vvps_pkg::VEL_W-1:0]        r_out_vel, n_out_vel;
    logic [2:0][vvps_pkg::VEL_W-1:0]        r_out_disp, n_out_disp;
    logic                                   r_out_rebuild, n_out_rebuild;

    logic signed [OP_W-1:0]                 w_mul_a, w_mul_b;
    logic [vvps_pkg::LEN_W-1:0]             w_len;
    logic                                   w_rebuild;

    // Saturate a wide signed value to 32 bits
    function automatic logic [vvps_pkg::VEL_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
        if (x > S32_MAX) begin
            return S32_MAX[vvps_pkg::VEL_W-1:0];
        end else if (x < S32_MIN) begin
            return S32_MIN[vvps_pkg::VEL_W-1:0];
        end
        return x[vvps_pkg::VEL_W-1:0];
    endfunction

    // Half kick: v + floor(f*dt / 2^(FRAC_BITS+1)), product already in prod
    function automatic logic [vvps_pkg::VEL_W-1:0] kick(input logic [vvps_pkg::VEL_W-1:0] v,
                                                        input logic signed [PROD_W-1:0] prod);
        logic signed [PROD_W-1:0] v_ext;
        v_ext = $signed({{(PROD_W - vvps_pkg::VEL_W){v[vvps_pkg::VEL_W-1]}}, v});
        return sat32(v_ext + (prod >>> (vvps_pkg::FRAC_BITS + 1)));
    endfunction

    // Single periodic wrap, then clamp into [0, len); all compares run in parallel
    function automatic logic [vvps_pkg::POS_W-1:0] wrap_pos(input logic signed [P_W-1:0] p,
                                                            input logic [vvps_pkg::LEN_W-1:0] len);
        logic signed [P_W-1:0] l1;
        logic signed [P_W-1:0] l2;
        logic signed [P_W-1:0] lm;
        l1 = $signed({3'b000, len});
        l2 = $signed({2'b00, len, 1'b0});
        lm = -l1;
        if (p >= l2) begin
            return len - 1'b1;
        end else if (p >= l1) begin
            return vvps_pkg::POS_W'(p - l1);
        end else if (p < lm) begin
            return '0;
        end else if (p < 0) begin
            return vvps_pkg::POS_W'(p + l1);
        end
        return vvps_pkg::POS_W'(p);
    endfunction

    function automatic logic signed [OP_W-1:0] sx(input logic [vvps_pkg::VEL_W-1:0] x);
        return $signed({x[vvps_pkg::VEL_W-1], x});
    endfunction

    function automatic logic signed [P_W-1:0] pos_plus(input logic [vvps_pkg::POS_W-1:0] pos,
                                                       input logic [vvps_pkg::VEL_W-1:0] d);
        return $signed({3'b000, pos}) +
               $signed({{(P_W - vvps_pkg::VEL_W){d[vvps_pkg::VEL_W-1]}}, d});
    endfunction

    // Zero box length acts as one
    assign w_len     = (i_cfg.box_length == '0) ? vvps_pkg::LEN_W'(1) : i_cfg.box_length;
    assign w_rebuild = r_pbig > BIG_W'(r_s2q);

    assign o_pop          = (r_state == S_IDLE) && i_q_valid;
    assign o_out_valid    = r_out_valid;
    assign o_new_pos      = r_out_pos;
    assign o_new_vel      = r_out_vel;
    assign o_disp         = r_out_disp;
    assign o_rebuild_list = r_out_rebuild;

    // Shared multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_KX: begin
                w_mul_a = sx(r_item.force_in[0]);
                w_mul_b = $signed(OP_W'(i_cfg.time_step));
            end
            S_KY: begin
                w_mul_a = sx(r_item.force_in[1]);
                w_mul_b = $signed(OP_W'(i_cfg.time_step));
            end
            S_KZ: begin
                w_mul_a = sx(r_item.force_in[2]);
                w_mul_b = $signed(OP_W'(i_cfg.time_step));
            end
            S_DX: begin
                w_mul_a = sx(r_vel[0]);
                w_mul_b = $signed(OP_W'(i_cfg.time_step));
            end
            S_DY: begin
                w_mul_a = sx(r_vel[1]);
                w_mul_b = $signed(OP_W'(i_cfg.time_step));
            end
            S_DZ: begin
                w_mul_a = sx(r_vel[2]);
                w_mul_b = $signed(OP_W'(i_cfg.time_step));
            end
            S_SX: begin
                w_mul_a = sx(r_disp[0]);
                w_mul_b = sx(r_disp[0]);
            end
            S_SY: begin
                w_mul_a = sx(r_disp[1]);
                w_mul_b = sx(r_disp[1]);
            end
            S_SZ: begin
                w_mul_a = sx(r_disp[2]);
                w_mul_b = sx(r_disp[2]);
            end
            S_C2: begin
                w_mul_a = $signed(OP_W'(r_cnt));
                w_mul_b = $signed(OP_W'(r_cnt));
            end
            S_S2: begin
                w_mul_a = $signed(OP_W'(i_cfg.skin_margin));
                w_mul_b = $signed(OP_W'(i_cfg.skin_margin));
            end
            S_PL: begin
                w_mul_a = $signed(OP_W'(r_max[HALF_W-1:0]));
                w_mul_b = $signed(OP_W'(r_c2));
            end
            S_PH: begin
                w_mul_a = $signed(OP_W'(r_max[SQ_W-1:HALF_W]));
                w_mul_b = $signed(OP_W'(r_c2));
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Sequencer: one multiply issued per step, its product used in the next step
    always_comb begin
        n_state       = r_state;
        n_item        = r_item;
        n_vel         = r_vel;
        n_disp        = r_disp;
        n_npos        = r_npos;
        n_rebuild     = r_rebuild;
        n_prod        = w_mul_a * w_mul_b;
        n_p           = r_p;
        n_acc         = r_acc;
        n_max         = r_max;
        n_pass_open   = r_pass_open;
        n_cnt         = r_cnt;
        n_c2          = r_c2;
        n_s2q         = r_s2q;
        n_pl          = r_pl;
        n_pbig        = r_pbig;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_pos     = r_out_pos;
        n_out_vel     = r_out_vel;
        n_out_disp    = r_out_disp;
        n_out_rebuild = r_out_rebuild;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_item    = i_q_item;
                    n_npos    = i_q_item.pos;
                    n_disp    = '0;
                    n_rebuild = 1'b0;
                    n_state   = S_KX;
                end
            end
            S_KX: n_state = S_KY;
            S_KY: begin
                n_vel[0] = kick(r_item.vel[0], r_prod);
                n_state  = S_KZ;
            end
            S_KZ: begin
                n_vel[1] = kick(r_item.vel[1], r_prod);
                n_state  = S_KEND;
            end
            S_KEND: begin
                n_vel[2] = kick(r_item.vel[2], r_prod);
                n_state  = (r_item.kind == vvps_pkg::KIND_KICK) ? S_DONE : S_DX;
            end
            S_DX: n_state = S_DY;
            S_DY: begin
                n_disp[0] = sat32(r_prod >>> vvps_pkg::FRAC_BITS);
                n_state   = S_DZ;
            end
            S_DZ: begin
                n_disp[1] = sat32(r_prod >>> vvps_pkg::FRAC_BITS);
                n_state   = S_DEND;
            end
            S_DEND: begin
                n_disp[2] = sat32(r_prod >>> vvps_pkg::FRAC_BITS);
                n_state   = S_SX;
            end
            // Squares accumulate while the coordinates wrap one after another
            S_SX: begin
                n_p     = pos_plus(r_item.pos[0], r_disp[0]);
                n_state = S_SY;
            end
            S_SY: begin
                n_acc     = r_prod[SQ_W-1:0];
                n_npos[0] = wrap_pos(r_p, w_len);
                n_p       = pos_plus(r_item.pos[1], r_disp[1]);
                n_state   = S_SZ;
            end
            S_SZ: begin
                n_acc     = r_acc + r_prod[SQ_W-1:0];
                n_npos[1] = wrap_pos(r_p, w_len);
                n_p       = pos_plus(r_item.pos[2], r_disp[2]);
                n_state   = S_SEND;
            end
            S_SEND: begin
                n_acc     = r_acc + r_prod[SQ_W-1:0];
                n_npos[2] = wrap_pos(r_p, w_len);
                n_state   = S_MAX;
            end
            // Running maximum of the pass; the first drift item opens it
            S_MAX: begin
                if (!r_pass_open || (r_acc > r_max)) begin
                    n_max = r_acc;
                end
                if (r_item.kind == vvps_pkg::KIND_DRIFT_LAST) begin
                    n_pass_open = 1'b0;
                    n_cnt       = (r_cnt == CNT_TOP) ? r_cnt : r_cnt + 1'b1;
                    n_state     = S_C2;
                end else begin
                    n_pass_open = 1'b1;
                    n_state     = S_DONE;
                end
            end
            // Rebuild test: max*cnt^2 > floor(skin^2/4), product in two halves
            S_C2: n_state = S_S2;
            S_S2: begin
                n_c2    = r_prod[C2_W-1:0];
                n_state = S_PL;
            end
            S_PL: begin
                n_s2q   = r_prod[2*vvps_pkg::LEN_W-1:2];
                n_state = S_PH;
            end
            S_PH: begin
                n_pl    = r_prod[SQ_W-1:0];
                n_state = S_PSUM;
            end
            S_PSUM: begin
                n_pbig  = {r_prod[SQ_W-1:0], {HALF_W{1'b0}}} + BIG_W'(r_pl);
                n_state = S_CMP;
            end
            S_CMP: begin
                if (w_rebuild) begin
                    n_rebuild = 1'b1;
                    n_cnt     = '0;
                end
                n_state = S_DONE;
            end
            // Hand the result to the output register once it is free
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid   = 1'b1;
                    n_out_pos     = r_npos;
                    n_out_vel     = r_vel;
                    n_out_disp    = r_disp;
                    n_out_rebuild = r_rebuild;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_max       <= '0;
            r_pass_open <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_max         <= n_max;
            r_pass_open   <= n_pass_open;
            r_cnt         <= n_cnt;
            r_item        <= n_item;
            r_vel         <= n_vel;
            r_disp        <= n_disp;
            r_npos        <= n_npos;
            r_rebuild     <= n_rebuild;
            r_prod        <= n_prod;
            r_p           <= n_p;
            r_acc         <= n_acc;
            r_c2          <= n_c2;
            r_s2q         <= n_s2q;
            r_pl          <= n_pl;
            r_pbig        <= n_pbig;
            r_out_pos     <= n_out_pos;
            r_out_vel     <= n_out_vel;
            r_out_disp    <= n_out_disp;
            r_out_rebuild <= n_out_rebuild;
        end
    end

    // A new result only ever comes out of the hand-over step
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result appeared outside hand-over");

    // The rebuild test only runs after the pass has been closed
    a_cmp_pass_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> !r_pass_open)
        else $error("rebuild test with pass still open");

    // A rebuild restarts the step count
    a_rebuild_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CMP) && w_rebuild) |=> (r_cnt == '0))
        else $error("step count not cleared on rebuild");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import vvps_pkg::*;

    // Action codes of an input item
    localparam logic ACT_DRIFT = 1'b0;
    localparam logic ACT_KICK  = 1'b1;

    localparam int     HALF_PERIOD   = 5;
    localparam int     SETTLE_CYCLES = 40;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     PASS_RUN      = 30;
    localparam longint CYCLE_LIMIT   = 64'd6_000_000;

    localparam longint S32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint S32_MIN = -64'sh0000_0000_8000_0000;

    localparam logic [VEL_W-1:0] VEL_MAX = 32'h7FFF_FFFF;
    localparam logic [VEL_W-1:0] VEL_MIN = 32'h8000_0000;
    localparam logic [POS_W-1:0] POS_MAX = 31'h7FFF_FFFF;
    localparam logic [LEN_W-1:0] LEN_MAX = 31'h7FFF_FFFF;
    localparam logic [DT_W-1:0]  DT_MAX  = 17'd65536;

    typedef struct packed {
        logic                  action;
        logic                  last;
        logic [2:0][POS_W-1:0] pos;
        logic [2:0][VEL_W-1:0] vel;
        logic [2:0][VEL_W-1:0] frc;
    } particle_t;

    typedef struct packed {
        logic [2:0][POS_W-1:0] pos;
        logic [2:0][VEL_W-1:0] vel;
        logic [2:0][VEL_W-1:0] disp;
        logic                  rebuild;
    } step_t;

    // Stimulus side
    logic                 i_clk     = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = CFG_TIME_STEP;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 in_valid  = 1'b0;
    particle_t            drive_p   = '0;
    logic                 out_stall = 1'b0;

    // Block outputs
    logic             o_in_stall;
    logic             o_out_valid;
    logic [POS_W-1:0] o_new_pos_x, o_new_pos_y, o_new_pos_z;
    logic [VEL_W-1:0] o_new_vel_x, o_new_vel_y, o_new_vel_z;
    logic [VEL_W-1:0] o_disp_x, o_disp_y, o_disp_z;
    logic             o_rebuild_list;

    // Predictor copy of registers and state
    longint          dt_q         = longint'(RST_TIME_STEP);
    longint          len_q        = longint'(RST_BOX_LENGTH);
    longint unsigned skin_q       = 64'(RST_SKIN_MARGIN);
    longint unsigned peak_sq_disp = 0;
    longint unsigned pass_count   = 0;
    logic            pass_active  = 1'b0;

    step_t pending_steps[$];
    step_t oldest;

    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     hold_requests  = 0;
    int     hold_seen      = 0;
    int     hold_left      = 0;
    int     mismatch_count = 0;
    int     particles_sent = 0;
    int     pass_ends      = 0;
    int     rebuilds       = 0;
    int     settings_used  = 1;
    longint cycle_count    = 0;

    velocity_verlet_particle_step_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (drive_p.action),
        .i_pos_x         (drive_p.pos[0]),
        .i_pos_y         (drive_p.pos[1]),
        .i_pos_z         (drive_p.pos[2]),
        .i_vel_x         (drive_p.vel[0]),
        .i_vel_y         (drive_p.vel[1]),
        .i_vel_z         (drive_p.vel[2]),
        .i_force_x       (drive_p.frc[0]),
        .i_force_y       (drive_p.frc[1]),
        .i_force_z       (drive_p.frc[2]),
        .i_last_particle (drive_p.last),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_new_pos_x     (o_new_pos_x),
        .o_new_pos_y     (o_new_pos_y),
        .o_new_pos_z     (o_new_pos_z),
        .o_new_vel_x     (o_new_vel_x),
        .o_new_vel_y     (o_new_vel_y),
        .o_new_vel_z     (o_new_vel_z),
        .o_disp_x        (o_disp_x),
        .o_disp_y        (o_disp_y),
        .o_disp_z        (o_disp_z),
        .o_rebuild_list  (o_rebuild_list)
    );

    // Clock
    always #HALF_PERIOD i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_steps.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic longint clamp_s32(longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    // Half kick, drift and single wrap of one particle; tracks the pass peak
    // and the rebuild test on the last drift particle
    function automatic step_t integrate_particle(particle_t p);
        step_t           r;
        longint          v, f, d, q, len;
        longint unsigned dr2, k, s2;
        int              i;
        r   = '0;
        dr2 = 0;
        len = (len_q == 0) ? 64'sd1 : len_q;
        for (i = 0; i < 3; i++) begin
            v = longint'($signed(p.vel[i]));
            f = longint'($signed(p.frc[i]));
            v = clamp_s32(v + ((f * dt_q) >>> (FRAC_BITS + 1)));
            r.vel[i] = v[VEL_W-1:0];
            r.pos[i] = p.pos[i];
            if (p.action == ACT_DRIFT) begin
                d   = clamp_s32((v * dt_q) >>> FRAC_BITS);
                dr2 += d * d;
                q   = longint'(p.pos[i]) + d;
                if (q >= len) q -= len;
                else if (q < 0) q += len;
                // still outside the box after one wrap: clamp
                if (q < 0) q = 0;
                if (q > len - 1) q = len - 1;
                r.pos[i]  = q[POS_W-1:0];
                r.disp[i] = d[VEL_W-1:0];
            end
        end
        if (p.action == ACT_DRIFT) begin
            if (!pass_active || dr2 > peak_sq_disp) peak_sq_disp = dr2;
            pass_active = 1'b1;
            if (p.last) begin
                if (pass_count < 65535) pass_count++;
                // 4*peak*n^2 > skin^2, compared by division to stay in range
                k  = 4 * pass_count * pass_count;
                s2 = skin_q * skin_q;
                if (k != 0 && peak_sq_disp > s2 / k) begin
                    r.rebuild  = 1'b1;
                    pass_count = 0;
                    rebuilds++;
                end
                pass_active = 1'b0;
                pass_ends++;
            end
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch %s at cycle %0d: expected %h, got %h",
                         name, cycle_count, want, got);
        end
    endfunction

    // Result checker against the oldest expectation
    always @(posedge i_clk) begin
        if (rst_n && o_out_valid === 1'b1 && !out_stall) begin
            if (pending_steps.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result with nothing expected at cycle %0d", cycle_count);
            end else begin
                oldest = pending_steps.pop_front();
                check_field("new_pos_x", 32'(oldest.pos[0]), 32'(o_new_pos_x));
                check_field("new_pos_y", 32'(oldest.pos[1]), 32'(o_new_pos_y));
                check_field("new_pos_z", 32'(oldest.pos[2]), 32'(o_new_pos_z));
                check_field("new_vel_x", oldest.vel[0], o_new_vel_x);
                check_field("new_vel_y", oldest.vel[1], o_new_vel_y);
                check_field("new_vel_z", oldest.vel[2], o_new_vel_z);
                check_field("disp_x", oldest.disp[0], o_disp_x);
                check_field("disp_y", oldest.disp[1], o_disp_y);
                check_field("disp_z", oldest.disp[2], o_disp_z);
                check_field("rebuild_list", 32'(oldest.rebuild), 32'(o_rebuild_list));
            end
        end
    end

    // Offer one item, hold it until taken, then log what it should produce
    task automatic send_particle(input particle_t p);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        drive_p  <= p;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        pending_steps.push_back(integrate_particle(p));
        particles_sent++;
    endtask

    // Sender pauses until every result is back and the block has gone quiet
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_steps.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all three registers, one per cycle
    task automatic write_config(input longint unsigned dt, input longint unsigned len,
                                input longint unsigned skin);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_TIME_STEP;
        cfg_wdata <= CFG_W'(dt);
        @(posedge i_clk);
        dt_q      = longint'(dt & 64'h1_FFFF);
        cfg_idx   <= CFG_BOX_LENGTH;
        cfg_wdata <= CFG_W'(len);
        @(posedge i_clk);
        len_q     = longint'(len & 64'h7FFF_FFFF);
        cfg_idx   <= CFG_SKIN_MARGIN;
        cfg_wdata <= CFG_W'(skin);
        @(posedge i_clk);
        skin_q    = skin & 64'h7FFF_FFFF;
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // Same values on all three axes
    function automatic particle_t mk_particle(logic action, logic last, logic [POS_W-1:0] pos,
                                              logic [VEL_W-1:0] vel, logic [VEL_W-1:0] frc);
        particle_t p;
        p.action = action;
        p.last   = last;
        p.pos    = {3{pos}};
        p.vel    = {3{vel}};
        p.frc    = {3{frc}};
        return p;
    endfunction

    // Signed value of random magnitude, extremes now and then
    function automatic logic [VEL_W-1:0] rand_signed();
        int t;
        t = $urandom;
        case ($urandom_range(15))
            0:       return VEL_MAX;
            1:       return VEL_MIN;
            2:       return '0;
            default: return t >>> $urandom_range(31);
        endcase
    endfunction

    function automatic particle_t rand_particle(logic action, logic last);
        particle_t p;
        int        i;
        p.action = action;
        p.last   = last;
        for (i = 0; i < 3; i++) begin
            // mostly inside the box, sometimes anywhere
            if ($urandom_range(7) == 0) p.pos[i] = POS_W'($urandom);
            else p.pos[i] = POS_W'($urandom % ((len_q == 0) ? 64'sd1 : len_q));
            p.vel[i] = rand_signed();
            p.frc[i] = rand_signed();
        end
        return p;
    endfunction

    // Mostly drift passes closed by a last particle, kick sweeps and stray items
    task automatic drive_random_passes(input int count);
        int sent, n, j;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(9))
                0: begin
                    send_particle(rand_particle(1'($urandom), 1'($urandom)));
                    sent++;
                end
                1, 2: begin
                    n = $urandom_range(6, 1);
                    for (j = 0; j < n; j++)
                        send_particle(rand_particle(ACT_KICK, j == n - 1));
                    sent += n;
                end
                default: begin
                    n = $urandom_range(8, 1);
                    for (j = 0; j < n; j++)
                        send_particle(rand_particle(ACT_DRIFT, j == n - 1));
                    sent += n;
                end
            endcase
        end
    endtask

    // Field extremes, wraps, clamps, pass boundaries, zero box
    task automatic test_directed();
        // registers still at their reset values
        send_particle(mk_particle(ACT_KICK, 1'b1, '0, VEL_MAX, VEL_MAX));
        send_particle(mk_particle(ACT_KICK, 1'b0, POS_MAX, VEL_MIN, VEL_MIN));
        send_particle(mk_particle(ACT_DRIFT, 1'b0, '0, -32'sd6553600, '0));
        send_particle(mk_particle(ACT_DRIFT, 1'b0, 31'd655359, 32'sd6553600, '0));
        send_particle(mk_particle(ACT_DRIFT, 1'b0, POS_MAX, '0, 32'h0001_0000));
        send_particle(mk_particle(ACT_DRIFT, 1'b1, 31'd327680, 32'h0001_0000, 32'hFFFF_0000));
        send_particle(mk_particle(ACT_DRIFT, 1'b1, 31'd100, 32'h0002_0000, '0));
        drain_results();

        // largest step: velocity saturates, zero skin
        write_config(DT_MAX, 64'd65536000, 0);
        send_particle(mk_particle(ACT_DRIFT, 1'b0, 31'd65535999, VEL_MAX, VEL_MAX));
        send_particle(mk_particle(ACT_DRIFT, 1'b0, '0, VEL_MIN, VEL_MIN));
        send_particle(mk_particle(ACT_DRIFT, 1'b1, 31'd5, '0, '0));
        // fresh pass with zero peak: no flag even with zero skin
        send_particle(mk_particle(ACT_DRIFT, 1'b1, 31'd5, '0, '0));
        send_particle(mk_particle(ACT_KICK, 1'b1, 31'd7, VEL_MAX, 32'h0000_0001));
        drain_results();

        // zero box length acts as one, zero step, widest skin
        write_config(0, 0, LEN_MAX);
        send_particle(mk_particle(ACT_DRIFT, 1'b0, POS_MAX, VEL_MAX, VEL_MIN));
        send_particle(mk_particle(ACT_DRIFT, 1'b1, '0, VEL_MIN, VEL_MAX));
        send_particle(mk_particle(ACT_KICK, 1'b1, POS_MAX, VEL_MIN, VEL_MIN));
        drain_results();
    endtask

    // Random passes under several settings and idle patterns
    task automatic test_random_traffic();
        int send_pct[4] = '{0, 82, 0, 17};
        int recv_pct[4] = '{0, 0, 82, 17};
        int seg;
        for (seg = 0; seg < 6; seg++) begin
            send_idle_pct  = send_pct[seg % 4];
            recv_stall_pct = recv_pct[seg % 4];
            case (seg)
                0:       write_config(RST_TIME_STEP, RST_BOX_LENGTH, RST_SKIN_MARGIN);
                1:       write_config(DT_MAX, LEN_MAX, LEN_MAX);
                2:       write_config(0, 1, 0);
                default: write_config($urandom_range(65536),
                                      $urandom_range(32'h7FFF_FFFF, 1) >> $urandom_range(15),
                                      $urandom >> $urandom_range(31, 1));
            endcase
            drive_random_passes(190);
            drain_results();
        end
    endtask

    // Receiver holds off while the sender keeps going, so the input backs up
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_config(RST_TIME_STEP, RST_BOX_LENGTH, RST_SKIN_MARGIN);
        hold_requests++;
        drive_random_passes(40);
        drain_results();
    endtask

    // Pass count keeps growing over passes that need no rebuild
    task automatic test_counter_growth();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // zero step: peak stays zero, so no pass ever flags
        write_config(0, RST_BOX_LENGTH, LEN_MAX);
        repeat (PASS_RUN) send_particle(rand_particle(ACT_DRIFT, 1'b1));
        drain_results();
        // one pass alone stays under this skin, a long run of passes goes over it
        write_config(DT_MAX, RST_BOX_LENGTH, 64'd1_000_000);
        send_particle(mk_particle(ACT_DRIFT, 1'b1, '0, 32'h0001_0000, '0));
        drain_results();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_traffic();
        test_backpressure();
        test_counter_growth();

        $display("Sent %0d particles under %0d register settings with mixed idle patterns;",
                 particles_sent, settings_used);
        $display("%0d drift passes closed, %0d rebuilds flagged, %0d mismatches.",
                 pass_ends, rebuilds, mismatch_count);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== velocity_verlet_particle_step_top.f =====
src/vvps_pkg.sv
src/vvps_front.sv
src/vvps_back.sv
src/velocity_verlet_particle_step_top.sv
tb/sv/tb.sv
